FILE: rtl/core/vtm_pkg.sv
// ----------------------------------------------------------------------------
// vtm_pkg: shared types and constants of the virtual timer multiplexer
// Transaction payloads, command and result codes, controller states and the
// control and chain structs passed between the controller and the timer cells.
// ----------------------------------------------------------------------------
package vtm_pkg;

   localparam int NUM_TIMERS_DEFAULT = 8;
   localparam int INDEX_W            = 3;
   localparam int TIMER_SLOTS        = 1 << INDEX_W;   // timers a command can address
   localparam int TIME_W             = 32;
   localparam int WAIT_W             = 31;
   localparam int MAX_FIRES          = 8;               // fires per scan at most
   localparam int FIRE_CNT_W         = $clog2(MAX_FIRES + 1);
   localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

   typedef enum logic [2:0] {
      FUNC_START_PERIODIC = 3'd0,
      FUNC_START_ONE_SHOT = 3'd1,
      FUNC_CANCEL_ONE     = 3'd2,
      FUNC_CANCEL_ALL     = 3'd3,
      FUNC_TICK           = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      KIND_FIRE       = 2'd0,
      KIND_SUMMARY    = 2'd1,
      KIND_CANCEL_ACK = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP_ELAPSED,
      ST_PREP_WAIT,
      ST_WALK,
      ST_ACK
   } state_type;

   typedef struct packed {
      logic [2:0]        func;
      logic [INDEX_W-1:0] timer_index;
      logic [TIME_W-1:0] now;
      logic [WAIT_W-1:0] interval;
   } req_type;

   typedef struct packed {
      logic [1:0]         event_kind;
      logic [INDEX_W-1:0] fired_index;
      logic [WAIT_W-1:0]  next_wait;
      logic               wait_valid;
      logic               last;
   } rsp_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic               start_we;
      logic               one_shot;
      logic               cancel_one;
      logic               cancel_all;
      logic [INDEX_W-1:0] index;
      logic [TIME_W-1:0]  wr_time;
      logic [WAIT_W-1:0]  wr_period;
      logic [TIME_W-1:0]  scan_now;
      logic               calc_elapsed;
      logic               calc_wait;
      logic               step;
   } cell_ctl_type;

   // Scan token and running summary handed from cell to cell
   typedef struct packed {
      logic                  token;
      logic [FIRE_CNT_W-1:0] count;
      logic [WAIT_W-1:0]     best;
      logic                  any;
   } chain_type;

endpackage

FILE: rtl/core/vtm_cell.sv
// ----------------------------------------------------------------------------
// vtm_cell: one virtual timer slot of the cell chain
// Holds one timer, precomputes its wait figures from the scan time, and when
// the scan token reaches it, fires if due and folds its wait into the chain.
// ----------------------------------------------------------------------------
module vtm_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vtm_pkg::cell_ctl_type ctl,
   input  vtm_pkg::chain_type    chain_in,
   output vtm_pkg::chain_type    chain_out,
   output logic                 fire
);
   import vtm_pkg::*;

   localparam bit                 ADDRESSABLE = CELL_INDEX < TIMER_SLOTS;
   localparam logic [INDEX_W-1:0] MY_INDEX    = INDEX_W'(CELL_INDEX);

   logic              running_ff, running_in;
   logic              one_shot_ff, one_shot_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic [WAIT_W-1:0] period_ff, period_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic              expired_ff, expired_in;
   logic [WAIT_W-1:0] rem_idle_ff, rem_idle_in;
   logic [WAIT_W-1:0] rem_fired_ff, rem_fired_in;
   chain_type         chain_ff, chain_in_nxt;

   logic              selected;
   logic [TIME_W:0]   to_go;        // period - elapsed
   logic [TIME_W+1:0] to_go_next;   // 2*period - elapsed
   logic              due;
   logic              still;
   logic [WAIT_W-1:0] rem;

   assign selected = ADDRESSABLE && (ctl.index == MY_INDEX);

   // wait figures, computed ahead of the token
   always_comb begin
      to_go      = {2'b00, period_ff} - {1'b0, elapsed_ff};
      to_go_next = {2'b00, period_ff, 1'b0} - {2'b00, elapsed_ff};
      expired_in   = expired_ff;
      rem_idle_in  = rem_idle_ff;
      rem_fired_in = rem_fired_ff;
      if (ctl.calc_wait) begin
         expired_in   = to_go[TIME_W] || (to_go == '0);
         rem_idle_in  = expired_in ? '0 : to_go[WAIT_W-1:0];
         rem_fired_in = (to_go_next[TIME_W+1] || (to_go_next == '0)) ? '0
                                                                    : to_go_next[WAIT_W-1:0];
      end
      elapsed_in = ctl.calc_elapsed ? (ctl.scan_now - start_ff) : elapsed_ff;
   end

   // token visit
   always_comb begin
      due   = running_ff && expired_ff && (chain_in.count < FIRE_CNT_W'(MAX_FIRES));
      fire  = ctl.step && chain_in.token && due;
      still = running_ff && !(due && one_shot_ff);
      rem   = due ? rem_fired_ff : rem_idle_ff;

      chain_in_nxt.token = chain_in.token;
      chain_in_nxt.count = chain_in.count + FIRE_CNT_W'(due);
      chain_in_nxt.best  = (still && (!chain_in.any || (rem < chain_in.best))) ? rem
                                                                               : chain_in.best;
      chain_in_nxt.any   = chain_in.any || still;
   end

   // timer state
   always_comb begin
      running_in  = running_ff;
      one_shot_in = one_shot_ff;
      start_in    = start_ff;
      period_in   = period_ff;
      if (ctl.start_we && selected) begin
         running_in  = 1'b1;
         one_shot_in = ctl.one_shot;
         start_in    = ctl.wr_time;
         period_in   = ctl.wr_period;
      end else if (ctl.cancel_all || (ctl.cancel_one && selected)) begin
         running_in = 1'b0;
      end else if (fire) begin
         if (one_shot_ff) begin
            running_in = 1'b0;
         end else begin
            start_in = start_ff + {1'b0, period_ff};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         one_shot_ff <= 1'b0;
         chain_ff    <= '0;
      end else begin
         running_ff  <= running_in;
         one_shot_ff <= one_shot_in;
         if (ctl.step) begin
            chain_ff <= chain_in_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      period_ff    <= period_in;
      elapsed_ff   <= elapsed_in;
      expired_ff   <= expired_in;
      rem_idle_ff  <= rem_idle_in;
      rem_fired_ff <= rem_fired_in;
   end

   assign chain_out = chain_ff;

endmodule

FILE: rtl/core/virtual_timer_multiplexer.sv
// ----------------------------------------------------------------------------
// virtual_timer_multiplexer: NUM_TIMERS virtual timers on one free-running count
// Start, cancel and tick commands; a scan emits one fire transaction per due
// timer, then a summary with the smallest remaining wait.
// ----------------------------------------------------------------------------
// Each timer lives in its own cell of a chain. A start or tick transaction
// first passes the ST_PREP_ELAPSED and ST_PREP_WAIT states, in which every
// cell works out, in parallel, the elapsed time since its start and then its
// remaining wait (as is, and as it would be after firing). A scan token then
// walks the chain one cell per cycle while not stalled, carrying the fire
// count and the smallest wait seen so far; a due cell fires as the token
// passes. When the token leaves the last cell, the summary goes out with
// last set. The token only moves when the result register can take a value,
// so the scan stalls while rsp_ready is low and a result is pending.
// Cancel commands produce a single acknowledge transaction once the result
// register can take a value. Unknown command codes are accepted and dropped.
// A new command is taken only once the previous one has produced its final
// result. Timer indexes at or above NUM_TIMERS address no timer: a start
// still scans and a cancel is still acknowledged. At most eight timers fire
// per scan; any further due timers fire on a later tick.
module virtual_timer_multiplexer #(
   parameter int NUM_TIMERS = vtm_pkg::NUM_TIMERS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vtm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vtm_pkg::rsp_type rsp_data
);
   import vtm_pkg::*;

   state_type             state_ff, state_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic                  inject_ff, inject_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic                  slot_free;
   logic                  step;
   logic                  rsp_load;
   rsp_type               rsp_next;
   cell_ctl_type          ctl;
   chain_type             links [NUM_TIMERS+1];
   logic [NUM_TIMERS-1:0] fire_vec;
   logic [INDEX_W-1:0]    fired_index;
   chain_type             tail;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign tail      = links[NUM_TIMERS];

   // chain head: fresh token with an empty summary
   assign links[0] = {inject_ff, FIRE_CNT_W'(0), WAIT_MAX, 1'b0};

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.func)
                  FUNC_START_PERIODIC, FUNC_START_ONE_SHOT, FUNC_TICK: begin
                     state_in = ST_PREP_ELAPSED;
                  end
                  FUNC_CANCEL_ONE, FUNC_CANCEL_ALL: begin
                     state_in = ST_ACK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_PREP_ELAPSED: begin
            state_in = ST_PREP_WAIT;
         end
         ST_PREP_WAIT: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (slot_free && tail.token) begin
               state_in = ST_IDLE;
            end
         end
         ST_ACK: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_ready = 1'b0;
      step      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_WALK: begin
            step = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase

      // cell broadcast
      ctl.start_we     = accept && ((req_data.func == FUNC_START_PERIODIC) ||
                                    (req_data.func == FUNC_START_ONE_SHOT));
      ctl.one_shot     = req_data.func == FUNC_START_ONE_SHOT;
      ctl.cancel_one   = accept && (req_data.func == FUNC_CANCEL_ONE);
      ctl.cancel_all   = accept && (req_data.func == FUNC_CANCEL_ALL);
      ctl.index        = req_data.timer_index;
      ctl.wr_time      = req_data.now;
      ctl.wr_period    = req_data.interval;
      ctl.scan_now     = now_ff;
      ctl.calc_elapsed = state_ff == ST_PREP_ELAPSED;
      ctl.calc_wait    = state_ff == ST_PREP_WAIT;
      ctl.step         = step;
   end

   // which cell fired (token is in one cell at a time)
   always_comb begin
      fired_index = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (fire_vec[i]) begin
            fired_index = fired_index | INDEX_W'(i);
         end
      end
   end

   // result register source
   always_comb begin
      rsp_load = 1'b0;
      rsp_next = '0;
      if ((state_ff == ST_ACK) && slot_free) begin
         rsp_load            = 1'b1;
         rsp_next.event_kind = KIND_CANCEL_ACK;
         rsp_next.last       = 1'b1;
      end else if (step && (|fire_vec)) begin
         rsp_load             = 1'b1;
         rsp_next.event_kind  = KIND_FIRE;
         rsp_next.fired_index = fired_index;
      end else if (step && tail.token) begin
         rsp_load            = 1'b1;
         rsp_next.event_kind = KIND_SUMMARY;
         rsp_next.next_wait  = tail.any ? tail.best : '0;
         rsp_next.wait_valid = tail.any;
         rsp_next.last       = 1'b1;
      end

      rsp_in       = rsp_load ? rsp_next : rsp_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
      now_in       = accept ? req_data.now : now_ff;
      inject_in    = (state_ff == ST_PREP_WAIT) || (inject_ff && !step);
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inject_ff    <= inject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      rsp_ff <= rsp_in;
   end

   // ---------------------------------------------------------------- cell chain
   for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
      vtm_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .chain_in (links[g]),
         .chain_out(links[g+1]),
         .fire     (fire_vec[g])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
